// ===== hdl/websocket_frame_deframer_macros.svh =====
// assertion macros for the websocket frame deframer
// used by the top level only, no other dependencies
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
// no dependencies
package wsd_pkg;

  // width of the payload length counter
  localparam int LEN_WIDTH = 64;
  // width used to compare the length against the 32-bit limit
  localparam int CMP_W = (LEN_WIDTH > 32) ? LEN_WIDTH : 32;
  // header byte counter, enough for the eight bytes of a 64-bit length
  localparam int CNT_W = 3;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;
  localparam logic [6:0]  LEN_CODE_16   = 7'd126;
  localparam logic [6:0]  LEN_CODE_64   = 7'd127;
  localparam logic [CNT_W-1:0] EXT16_LAST = CNT_W'(1);
  localparam logic [CNT_W-1:0] EXT64_LAST = CNT_W'(7);
  localparam logic [CNT_W-1:0] MASK_LAST  = CNT_W'(3);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       last;
  } result_t;

  typedef struct packed {
    logic load;
    logic dead;
  } parse_status_t;

endpackage

// ===== hdl/wsd_in_stage.sv =====
// input register for the stream byte channel
// depends on nothing but the clock and reset
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] stream_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       full;
  logic [7:0] data;

  // a slot frees up in the same cycle the parser takes it
  assign byte_ready = !full || take;
  assign held_valid = full;
  assign held_byte  = data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // byte holding register
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      data <= stream_byte;
    end
  end

endmodule

// ===== hdl/wsd_hdr_parser.sv =====
// frame header parser and payload counter
// depends on wsd_pkg
module wsd_hdr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                out_space,
  input  logic [31:0]         max_len,
  output logic                take,
  output wsd_pkg::result_t    res,
  output wsd_pkg::parse_status_t status
);

  import wsd_pkg::*;

  phase_t               phase, phase_next;
  logic [3:0]           held_opcode, held_opcode_next;
  logic                 held_fin, held_fin_next;
  logic                 mask_present, mask_present_next;
  logic [CNT_W-1:0]     hdr_cnt, hdr_cnt_next;
  logic [LEN_WIDTH-1:0] remaining, remaining_next;
  logic                 len_ovf, len_ovf_next;

  logic [6:0]           code;
  logic [LEN_WIDTH-1:0] shifted;
  logic                 shift_ovf;
  logic [LEN_WIDTH-1:0] chk_len;
  logic                 chk_ovf;
  logic                 too_long;
  logic                 do_finish;
  logic                 load;

  assign take = in_valid && out_space;
  assign code = in_byte[6:0];

  // next length value while gathering extended length bytes
  assign shifted   = {remaining[LEN_WIDTH-9:0], in_byte};
  assign shift_ovf = (remaining[LEN_WIDTH-1 -: 8] != 8'd0);

  // length that reaches the limit check on this byte
  always_comb begin
    unique case (phase)
      PH_HDR1: begin
        chk_len = LEN_WIDTH'(code);
        chk_ovf = 1'b0;
      end
      PH_EXT16, PH_EXT64: begin
        chk_len = shifted;
        chk_ovf = len_ovf || shift_ovf;
      end
      default: begin
        chk_len = remaining;
        chk_ovf = len_ovf;
      end
    endcase
  end

  assign too_long = chk_ovf || (CMP_W'(chk_len) > CMP_W'(max_len));

  // next state and result
  always_comb begin
    phase_next        = phase;
    held_opcode_next  = held_opcode;
    held_fin_next     = held_fin;
    mask_present_next = mask_present;
    hdr_cnt_next      = hdr_cnt;
    remaining_next    = remaining;
    len_ovf_next      = len_ovf;
    do_finish         = 1'b0;
    load              = 1'b0;
    res.kind          = KIND_DATA;
    res.payload_byte  = 8'd0;
    res.frame_opcode  = held_opcode;
    res.frame_fin     = held_fin;
    res.last          = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        held_fin_next    = in_byte[7];
        held_opcode_next = in_byte[3:0];
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        mask_present_next = in_byte[7];
        len_ovf_next      = 1'b0;
        hdr_cnt_next      = '0;
        if (code == LEN_CODE_16) begin
          remaining_next = '0;
          phase_next     = PH_EXT16;
        end else if (code == LEN_CODE_64) begin
          remaining_next = '0;
          phase_next     = PH_EXT64;
        end else begin
          remaining_next = chk_len;
          if (in_byte[7]) begin
            phase_next = PH_MASK;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        remaining_next = shifted;
        len_ovf_next   = chk_ovf;
        hdr_cnt_next   = hdr_cnt + CNT_W'(1);
        if ((phase == PH_EXT16 && hdr_cnt == EXT16_LAST) ||
            (phase == PH_EXT64 && hdr_cnt == EXT64_LAST)) begin
          hdr_cnt_next = '0;
          if (mask_present) begin
            phase_next = PH_MASK;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      PH_MASK: begin
        hdr_cnt_next = hdr_cnt + CNT_W'(1);
        if (hdr_cnt == MASK_LAST) begin
          hdr_cnt_next = '0;
          do_finish    = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        load             = 1'b1;
        res.payload_byte = in_byte;
        if (remaining != '0) begin
          remaining_next = remaining - LEN_WIDTH'(1);
        end
        if (remaining <= LEN_WIDTH'(1)) begin
          res.last   = 1'b1;
          phase_next = PH_HDR0;
        end
      end
      PH_ERROR: begin
        phase_next = PH_ERROR;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    // end of header: limit check, then empty frame, else payload
    if (do_finish) begin
      if (too_long) begin
        phase_next = PH_ERROR;
        load       = 1'b1;
        res.kind   = KIND_ERROR;
      end else if (chk_len == '0) begin
        phase_next = PH_HDR0;
        load       = 1'b1;
        res.kind   = KIND_EMPTY;
        res.last   = 1'b1;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  assign status.load = take && load;
  assign status.dead = (phase == PH_ERROR);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      held_opcode  <= 4'd0;
      held_fin     <= 1'b0;
      mask_present <= 1'b0;
      hdr_cnt      <= '0;
      remaining    <= '0;
      len_ovf      <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      held_opcode  <= held_opcode_next;
      held_fin     <= held_fin_next;
      mask_present <= mask_present_next;
      hdr_cnt      <= hdr_cnt_next;
      remaining    <= remaining_next;
      len_ovf      <= len_ovf_next;
    end
  end

endmodule

// ===== hdl/wsd_out_stage.sv =====
// result register for the output channel
// depends on wsd_pkg
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsd_pkg::result_t res,
  output logic             space,
  output logic             result_valid,
  input  logic             result_ready,
  output wsd_pkg::result_t held
);

  import wsd_pkg::*;

  logic    full;
  result_t data;

  // room when empty or when the held transaction leaves this cycle
  assign space        = !full || result_ready;
  assign result_valid = full;
  assign held         = data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result_ready) begin
      full <= 1'b0;
    end
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// websocket frame deframer top level: input register, header parser, result register
// a byte goes from the input register through the parser into the result register;
// one byte per cycle sustained while result_ready is high, set by the single parser pass
// synchronous active-high reset: parser waits for a first header byte, limit is 65536
// depends on wsd_pkg, wsd_in_stage, wsd_hdr_parser, wsd_out_stage and the macros header
`include "websocket_frame_deframer_macros.svh"
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [3:0]  frame_opcode,
  output logic        frame_fin,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  import wsd_pkg::*;

  logic          take;
  logic          held_valid;
  logic [7:0]    held_byte;
  logic          space;
  logic [31:0]   max_len;
  result_t       res;
  result_t       out_res;
  parse_status_t status;

  // limit register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len <= cfg_data;
    end
  end

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .stream_byte(stream_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_hdr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (held_valid),
    .in_byte  (held_byte),
    .out_space(space),
    .max_len  (max_len),
    .take     (take),
    .res      (res),
    .status   (status)
  );

  wsd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (status.load),
    .res         (res),
    .space       (space),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .held        (out_res)
  );

  // result fields
  assign kind         = out_res.kind;
  assign payload_byte = out_res.payload_byte;
  assign frame_opcode = out_res.frame_opcode;
  assign frame_fin    = out_res.frame_fin;
  assign last         = out_res.last;

  // checks
  `WSD_ASSERT_NOW(a_err_not_last, clk, rst, result_valid && out_res.kind == KIND_ERROR,
                  !last, "length error marked last")
  `WSD_ASSERT_NOW(a_ctrl_no_data, clk, rst, result_valid && out_res.kind != KIND_DATA,
                  payload_byte == 8'd0, "data byte on non-data result")
  `WSD_ASSERT_NEXT(a_dead_sticky, clk, rst, status.dead, status.dead, "error lock released")
  `WSD_ASSERT_NOW(a_dead_silent, clk, rst, status.dead, !status.load, "result after error lock")

endmodule
